// File: hdl/efb_pkg.sv
// Package for the edge feature back-projection block: widths, register
// codes, reset values, the configuration struct and the divider dividend.
// No dependencies.
`timescale 1ns / 1ps

package efb_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int DEPTH_BITS_DEF = 16;

	localparam int FRAC_BITS   = 12;
	localparam int INV_SHIFT   = 16;
	localparam int DEPTH_SCALE = 5000;

	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CENTER_W   = 24;
	localparam int INV_W      = 16;
	localparam int LIMIT_W    = 16;
	localparam int ROWS_W     = 13;

	localparam int NORM_W     = 16;
	localparam int QUOT_W     = 25;
	localparam int PROJ_LAT   = 3;

	localparam int SAT_POS     = 32767;
	localparam int SAT_NEG_MAG = 32768;
	localparam int ROUND_ADD   = (1 << INV_SHIFT) - 1;

	// 5000 << 12, the constant numerator of the inverse depth
	localparam logic [QUOT_W-1:0] RECIP_NUM = QUOT_W'(DEPTH_SCALE << FRAC_BITS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_INV_FX     = 3'd2,
		REG_INV_FY     = 3'd3,
		REG_DEPTH_LO   = 3'd4,
		REG_DEPTH_HI   = 3'd5,
		REG_IMAGE_ROWS = 3'd6
	} cfg_reg_t;

	localparam logic [CENTER_W-1:0] RST_CENTER_X   = 24'd655360;
	localparam logic [CENTER_W-1:0] RST_CENTER_Y   = 24'd491520;
	localparam logic [INV_W-1:0]    RST_INV_FX     = 16'd124;
	localparam logic [INV_W-1:0]    RST_INV_FY     = 16'd124;
	localparam logic [LIMIT_W-1:0]  RST_DEPTH_LO   = 16'd0;
	localparam logic [LIMIT_W-1:0]  RST_DEPTH_HI   = 16'd65535;
	localparam logic [ROWS_W-1:0]   RST_IMAGE_ROWS = 13'd240;

	typedef struct packed {
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [INV_W-1:0]    inv_fx;
		logic [INV_W-1:0]    inv_fy;
		logic [LIMIT_W-1:0]  depth_lo;
		logic [LIMIT_W-1:0]  depth_hi;
		logic [ROWS_W-1:0]   image_rows;
	} cfg_t;

endpackage

// File: hdl/efb_cfg.sv
// Configuration register file of the back-projection block.
// Depends on efb_pkg.
`timescale 1ns / 1ps

module efb_cfg
	import efb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x   <= RST_CENTER_X;
			cfg_q.center_y   <= RST_CENTER_Y;
			cfg_q.inv_fx     <= RST_INV_FX;
			cfg_q.inv_fy     <= RST_INV_FY;
			cfg_q.depth_lo   <= RST_DEPTH_LO;
			cfg_q.depth_hi   <= RST_DEPTH_HI;
			cfg_q.image_rows <= RST_IMAGE_ROWS;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTER_X:   cfg_q.center_x   <= cfg_data[CENTER_W-1:0];
				REG_CENTER_Y:   cfg_q.center_y   <= cfg_data[CENTER_W-1:0];
				REG_INV_FX:     cfg_q.inv_fx     <= cfg_data[INV_W-1:0];
				REG_INV_FY:     cfg_q.inv_fy     <= cfg_data[INV_W-1:0];
				REG_DEPTH_LO:   cfg_q.depth_lo   <= cfg_data[LIMIT_W-1:0];
				REG_DEPTH_HI:   cfg_q.depth_hi   <= cfg_data[LIMIT_W-1:0];
				REG_IMAGE_ROWS: cfg_q.image_rows <= cfg_data[ROWS_W-1:0];
				default: ; // unused index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/efb_project.sv
// Three-stage projection of one coordinate: offset, multiply, floor-shift
// and saturate to Q4.12. Depends on efb_pkg.
`timescale 1ns / 1ps

module efb_project
	import efb_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic [COORD_BITS-1:0] pos,
	input  logic [CENTER_W-1:0]   center,
	input  logic [INV_W-1:0]      inv,
	output logic [NORM_W-1:0]     norm
);

	localparam int SCALED_W = COORD_BITS + FRAC_BITS;
	localparam int MAG_W    = (SCALED_W > CENTER_W) ? SCALED_W : CENTER_W;
	localparam int PROD_W   = MAG_W + INV_W;
	localparam int HI_W     = PROD_W + 1 - INV_SHIFT;

	logic [MAG_W-1:0]  scaled, center_ext;
	logic              neg;
	logic [MAG_W-1:0]  mag_s1;
	logic              neg_s1, neg_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [PROD_W:0]   rnd;
	logic [HI_W-1:0]   hi;
	logic [NORM_W-1:0] sat;
	logic [NORM_W-1:0] norm_s3;

	assign scaled     = MAG_W'({pos, FRAC_BITS'(0)});
	assign center_ext = MAG_W'(center);
	assign neg        = scaled < center_ext;

	always_ff @(posedge clk) begin
		neg_s1  <= neg;
		mag_s1  <= neg ? (center_ext - scaled) : (scaled - center_ext);
		neg_s2  <= neg_s1;
		prod_s2 <= PROD_W'(mag_s1) * PROD_W'(inv);
		norm_s3 <= sat;
	end

	// negative side: ceiling of the magnitude gives the floor of the value
	always_comb begin
		rnd = neg_s2 ? ({1'b0, prod_s2} + (PROD_W + 1)'(ROUND_ADD)) : {1'b0, prod_s2};
		hi  = rnd[PROD_W:INV_SHIFT];
		if (!neg_s2) begin
			sat = (hi > HI_W'(SAT_POS)) ? NORM_W'(SAT_POS) : NORM_W'(hi);
		end else begin
			sat = (hi > HI_W'(SAT_NEG_MAG)) ? NORM_W'(SAT_NEG_MAG) : NORM_W'(-hi);
		end
	end

	assign norm = norm_s3;

endmodule

// File: hdl/efb_recip_div.sv
// Pipelined restoring divider: constant numerator over the depth sample,
// one quotient bit per stage, valid bit carried alongside. Depends on efb_pkg.
`timescale 1ns / 1ps

module efb_recip_div
	import efb_pkg::*;
#(
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [DEPTH_BITS-1:0] divisor,
	output logic                  out_valid,
	output logic [QUOT_W-1:0]     quotient
);

	logic [DEPTH_BITS-1:0] rem_s [1:QUOT_W];
	logic [QUOT_W-1:0]     quo_s [1:QUOT_W];
	logic [DEPTH_BITS-1:0] div_s [1:QUOT_W-1];
	logic [QUOT_W:1]       vld_s;

	for (genvar g = 0; g < QUOT_W; g++) begin : g_stage
		logic [DEPTH_BITS-1:0] rem_in;
		logic [DEPTH_BITS-1:0] div_in;
		logic [QUOT_W-1:0]     quo_in;
		logic [DEPTH_BITS:0]   trial;
		logic                  take;

		// first stage starts from a zero remainder and the incoming divisor
		if (g == 0) begin : g_head
			assign rem_in = '0;
			assign quo_in = '0;
			assign div_in = divisor;
		end else begin : g_body
			assign rem_in = rem_s[g];
			assign quo_in = quo_s[g];
			assign div_in = div_s[g];
		end

		assign trial = {rem_in, RECIP_NUM[QUOT_W-1-g]};
		assign take  = trial >= {1'b0, div_in};

		always_ff @(posedge clk) begin
			rem_s[g+1] <= take ? DEPTH_BITS'(trial - {1'b0, div_in}) : DEPTH_BITS'(trial);
			quo_s[g+1] <= {quo_in[QUOT_W-2:0], take};
		end

		if (g < QUOT_W - 1) begin : g_div
			always_ff @(posedge clk) begin
				div_s[g+1] <= div_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[QUOT_W-1:1], in_valid};
		end
	end

	assign out_valid = vld_s[QUOT_W];
	assign quotient  = quo_s[QUOT_W];

endmodule

// File: hdl/edge_feature_backproject.sv
// Edge feature selection and pinhole back-projection, top level.
// Pipeline: a result strobes on done once the start transaction has passed
// the input register and the 25 divider stages, one quotient bit each.
// Throughput: one pixel per clock; busy is always low and the receiver
// cannot stall. Asynchronous active-low reset clears valid bits and loads
// the register defaults. Depends on efb_pkg, efb_cfg, efb_project, efb_recip_div.
`timescale 1ns / 1ps

module edge_feature_backproject
	import efb_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration write port
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	// pixel command
	input  logic                     start,
	output logic                     busy,
	input  logic [COORD_BITS-1:0]    pixel_x,
	input  logic [COORD_BITS-1:0]    pixel_y,
	input  logic                     is_edge,
	input  logic [DEPTH_BITS-1:0]    depth_sample,
	// feature result
	output logic                     done,
	output logic signed [NORM_W-1:0] u_norm,
	output logic signed [NORM_W-1:0] v_norm,
	output logic [QUOT_W-1:0]        inv_depth
);

	// projection finishes early; its results wait in a tap line for the divider
	localparam int ALIGN = QUOT_W - PROJ_LAT;
	localparam int ROW_W = (COORD_BITS + 1 > ROWS_W) ? COORD_BITS + 1 : ROWS_W;

	cfg_t cfg;

	logic                  row_ok, depth_ok, sel;
	logic [LIMIT_W-1:0]    depth_ext;
	logic                  valid_s1;
	logic [COORD_BITS-1:0] x_s1, y_s1;
	logic [DEPTH_BITS-1:0] depth_s1;
	logic [NORM_W-1:0]     u_proj, v_proj;
	logic [NORM_W-1:0]     u_dly [ALIGN];
	logic [NORM_W-1:0]     v_dly [ALIGN];

	efb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// never holds off a transaction
	assign busy = 1'b0;

	// selection: edge bit, row strictly inside the image, depth between limits
	assign row_ok    = (pixel_y != '0) &&
	                   ((ROW_W'(pixel_y) + ROW_W'(1)) < ROW_W'(cfg.image_rows));
	assign depth_ext = LIMIT_W'(depth_sample);
	assign depth_ok  = (depth_ext > cfg.depth_lo) && (depth_ext < cfg.depth_hi) &&
	                   (depth_ext != '0);
	assign sel       = start && is_edge && row_ok && depth_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= sel;
		end
	end

	always_ff @(posedge clk) begin
		x_s1     <= pixel_x;
		y_s1     <= pixel_y;
		depth_s1 <= depth_sample;
	end

	efb_project #(.COORD_BITS(COORD_BITS)) u_proj_x (
		.clk    (clk),
		.pos    (x_s1),
		.center (cfg.center_x),
		.inv    (cfg.inv_fx),
		.norm   (u_proj)
	);

	efb_project #(.COORD_BITS(COORD_BITS)) u_proj_y (
		.clk    (clk),
		.pos    (y_s1),
		.center (cfg.center_y),
		.inv    (cfg.inv_fy),
		.norm   (v_proj)
	);

	// valid bit rides with the divider, the longest path
	efb_recip_div #(.DEPTH_BITS(DEPTH_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.divisor   (depth_s1),
		.out_valid (done),
		.quotient  (inv_depth)
	);

	always_ff @(posedge clk) begin
		u_dly[0] <= u_proj;
		v_dly[0] <= v_proj;
	end

	for (genvar k = 1; k < ALIGN; k++) begin : g_align
		always_ff @(posedge clk) begin
			u_dly[k] <= u_dly[k-1];
			v_dly[k] <= v_dly[k-1];
		end
	end

	assign u_norm = u_dly[ALIGN-1];
	assign v_norm = v_dly[ALIGN-1];

endmodule
